// File: rtl/core/owb_pkg.sv
package owb_pkg;

    // phase timer width, holds the longest timed phase
    localparam int TIMER_BITS = 12;

    // presence wait counter width and widest register
    localparam int WAIT_BITS  = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int BYTE_BITS = 8;
    localparam int BIT_CNT_W = 4;
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = BIT_CNT_W'(BYTE_BITS);

    localparam logic [TIMER_BITS-1:0] BIT_GAP_US = TIMER_BITS'(2);

    // opcodes on the input channel
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRE_RESET_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SETTLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_RELEASE   = 3'd7;

    // register reset values
    localparam logic [7:0]  RST_PRE_RESET_HIGH   = 8'd50;
    localparam logic [9:0]  RST_RESET_LOW        = 10'd500;
    localparam logic [6:0]  RST_PRESENCE_SETTLE  = 7'd40;
    localparam logic [11:0] RST_PRESENCE_TIMEOUT = 12'd2000;
    localparam logic [9:0]  RST_RESET_RECOVER    = 10'd500;
    localparam logic [3:0]  RST_SLOT_LOW         = 4'd5;
    localparam logic [6:0]  RST_SLOT_HOLD        = 7'd65;
    localparam logic [3:0]  RST_READ_RELEASE     = 4'd5;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_RESET,
        CMD_WRITE,
        CMD_READ
    } t_cmd;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [BYTE_BITS-1:0] byte_in;
        logic                 line_level;
    } t_in_item;

    typedef struct packed {
        t_cmd                 cmd;
        logic [BYTE_BITS-1:0] byte_in;
        logic                 line_level;
    } t_cls_item;

    typedef struct packed {
        logic                 drive_low;
        logic                 busy_res;
        logic                 done_res;
        logic [BYTE_BITS-1:0] read_byte;
        logic                 presence;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

// File: rtl/core/owb_front.sv
module owb_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  owb_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_push,
    output owb_pkg::t_cls_item o_item
);
    import owb_pkg::*;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // decode the opcode into a command class
    always_comb begin
        o_item.byte_in    = i_in_data.byte_in;
        o_item.line_level = i_in_data.line_level;
        case (i_in_data.opcode)
            OP_RESET: o_item.cmd = CMD_RESET;
            OP_WRITE: o_item.cmd = CMD_WRITE;
            OP_READ:  o_item.cmd = CMD_READ;
            default:  o_item.cmd = CMD_TICK;
        endcase
    end

endmodule

// File: rtl/core/owb_queue.sv
module owb_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  owb_pkg::t_q_ctrl   i_ctrl,
    input  owb_pkg::t_cls_item i_item,
    output owb_pkg::t_q_stat   o_stat,
    output owb_pkg::t_cls_item o_item
);
    import owb_pkg::*;

    t_cls_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]       r_count,  n_count;

    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_ctrl.push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_ctrl.pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        case ({i_ctrl.push, i_ctrl.pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/core/owb_back.sv
module owb_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [owb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_q_valid,
    input  owb_pkg::t_cls_item                i_q_item,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output owb_pkg::t_out_item                o_out_data
);
    import owb_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_R_PRE,
        PH_R_LOW,
        PH_R_SETTLE,
        PH_R_WAIT,
        PH_R_RECOVER,
        PH_W_LOW,
        PH_W_HOLD,
        PH_W_GAP,
        PH_RD_PRE,
        PH_RD_LOW,
        PH_RD_REL,
        PH_RD_HOLD
    } t_phase;

    // timing registers
    logic [7:0]  r_pre_high;
    logic [9:0]  r_reset_low;
    logic [6:0]  r_settle;
    logic [11:0] r_timeout;
    logic [9:0]  r_recover;
    logic [3:0]  r_slot_low;
    logic [6:0]  r_slot_hold;
    logic [3:0]  r_rd_release;

    t_phase                  r_phase, n_phase;
    logic [TIMER_BITS-1:0]   r_timer, n_timer;
    logic [BIT_CNT_W-1:0]    r_bit_count, n_bit_count;
    logic [BYTE_BITS-1:0]    r_shift, n_shift;
    logic [WAIT_BITS-1:0]    r_wait, n_wait;
    logic                    r_presence, n_presence;
    logic [BYTE_BITS-1:0]    r_last_read, n_last_read;

    logic                    r_out_valid;
    t_out_item               r_out, n_out;

    logic                    pop;

    // take the next tick whenever the result register is free or draining
    assign pop         = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop       = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        logic                  v_adv;
        logic                  v_fin;
        logic                  v_drive;
        logic                  v_busy;
        logic [TIMER_BITS-1:0] v_len;
        logic [TIMER_BITS:0]   v_t;
        t_phase                v_ph;

        n_phase     = r_phase;
        n_timer     = r_timer;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_wait      = r_wait;
        n_presence  = r_presence;
        n_last_read = r_last_read;
        v_adv       = 1'b0;
        v_fin       = 1'b0;
        v_drive     = 1'b0;
        v_busy      = 1'b0;
        v_t         = '0;

        if (pop && r_phase == PH_IDLE && i_q_item.cmd != CMD_TICK) begin
            n_timer     = '0;
            n_bit_count = '0;
            n_wait      = '0;
            case (i_q_item.cmd)
                CMD_RESET: begin
                    n_presence = 1'b0;
                    n_phase    = PH_R_PRE;
                end
                CMD_WRITE: begin
                    n_shift = i_q_item.byte_in;
                    n_phase = PH_W_LOW;
                end
                default: begin
                    n_shift = '0;
                    n_phase = PH_RD_PRE;
                end
            endcase
        end

        v_ph = n_phase;

        // length of the current timed phase
        case (v_ph)
            PH_R_PRE:               v_len = TIMER_BITS'(r_pre_high);
            PH_R_LOW:               v_len = TIMER_BITS'(r_reset_low);
            PH_R_SETTLE:            v_len = TIMER_BITS'(r_settle);
            PH_R_RECOVER:           v_len = TIMER_BITS'(r_recover);
            PH_W_LOW, PH_RD_LOW:    v_len = TIMER_BITS'(r_slot_low);
            PH_W_HOLD, PH_RD_HOLD:  v_len = TIMER_BITS'(r_slot_hold);
            PH_W_GAP:               v_len = BIT_GAP_US;
            PH_RD_PRE, PH_RD_REL:   v_len = TIMER_BITS'(r_rd_release);
            default:                v_len = TIMER_BITS'(1);
        endcase
        if (v_len == '0) begin
            v_len = TIMER_BITS'(1);
        end

        if (pop && v_ph != PH_IDLE) begin
            v_busy  = 1'b1;
            v_drive = (v_ph inside {PH_R_LOW, PH_W_LOW, PH_RD_LOW}) ||
                      (v_ph == PH_W_HOLD && !n_shift[0]);

            if (v_ph == PH_R_WAIT) begin
                if (!i_q_item.line_level) begin
                    n_presence = 1'b1;
                    v_adv      = 1'b1;
                end else begin
                    n_wait = n_wait + 1'b1;
                    if (n_wait >= r_timeout) begin
                        n_presence = 1'b0;
                        v_adv      = 1'b1;
                    end
                end
            end else begin
                v_t = {1'b0, n_timer} + 1'b1;
                if (v_t >= {1'b0, v_len}) begin
                    v_adv = 1'b1;
                end else begin
                    n_timer = v_t[TIMER_BITS-1:0];
                end
            end

            if (v_adv) begin
                n_timer = '0;
                case (v_ph)
                    PH_R_PRE:     n_phase = PH_R_LOW;
                    PH_R_LOW:     n_phase = PH_R_SETTLE;
                    PH_R_SETTLE: begin
                        n_wait  = '0;
                        n_phase = PH_R_WAIT;
                    end
                    PH_R_WAIT:    n_phase = PH_R_RECOVER;
                    PH_W_LOW:     n_phase = PH_W_HOLD;
                    PH_W_HOLD:    n_phase = PH_W_GAP;
                    PH_W_GAP: begin
                        n_shift     = n_shift >> 1;
                        n_bit_count = n_bit_count + 1'b1;
                        if (n_bit_count >= BITS_PER_BYTE) begin
                            v_fin = 1'b1;
                        end else begin
                            n_phase = PH_W_LOW;
                        end
                    end
                    PH_RD_PRE:    n_phase = PH_RD_LOW;
                    PH_RD_LOW:    n_phase = PH_RD_REL;
                    PH_RD_REL: begin
                        n_shift = {i_q_item.line_level, n_shift[BYTE_BITS-1:1]};
                        n_phase = PH_RD_HOLD;
                    end
                    PH_RD_HOLD: begin
                        n_bit_count = n_bit_count + 1'b1;
                        if (n_bit_count >= BITS_PER_BYTE) begin
                            n_last_read = n_shift;
                            v_fin       = 1'b1;
                        end else begin
                            n_phase = PH_RD_LOW;
                        end
                    end
                    default:      v_fin = 1'b1;
                endcase
                if (v_fin) begin
                    n_phase     = PH_IDLE;
                    n_bit_count = '0;
                end
            end
        end

        n_out.drive_low = v_drive;
        n_out.busy_res  = v_busy;
        n_out.done_res  = v_fin;
        n_out.read_byte = n_last_read;
        n_out.presence  = n_presence;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_high   <= RST_PRE_RESET_HIGH;
            r_reset_low  <= RST_RESET_LOW;
            r_settle     <= RST_PRESENCE_SETTLE;
            r_timeout    <= RST_PRESENCE_TIMEOUT;
            r_recover    <= RST_RESET_RECOVER;
            r_slot_low   <= RST_SLOT_LOW;
            r_slot_hold  <= RST_SLOT_HOLD;
            r_rd_release <= RST_READ_RELEASE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PRE_RESET_HIGH:   r_pre_high   <= i_cfg_data[7:0];
                REG_RESET_LOW:        r_reset_low  <= i_cfg_data[9:0];
                REG_PRESENCE_SETTLE:  r_settle     <= i_cfg_data[6:0];
                REG_PRESENCE_TIMEOUT: r_timeout    <= i_cfg_data[11:0];
                REG_RESET_RECOVER:    r_recover    <= i_cfg_data[9:0];
                REG_SLOT_LOW:         r_slot_low   <= i_cfg_data[3:0];
                REG_SLOT_HOLD:        r_slot_hold  <= i_cfg_data[6:0];
                REG_READ_RELEASE:     r_rd_release <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_wait      <= '0;
            r_presence  <= 1'b0;
            r_last_read <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_wait      <= n_wait;
            r_presence  <= n_presence;
            r_last_read <= n_last_read;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (pop) begin
                r_out <= n_out;
            end
        end
    end

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_out_valid)
        else $error("popped tick produced no result");

    a_idle_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_bit_count == '0)
        else $error("bit count left over in idle");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= BITS_PER_BYTE)
        else $error("bit count past one byte");

    a_done_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && n_out.done_res) |=> (r_phase == PH_IDLE && r_out.busy_res))
        else $error("finished command did not return to idle");

endmodule

// File: rtl/core/one_wire_bus_master.sv
// one-wire bus master, one request per microsecond tick
// input channel: i_in_valid / o_in_ready with i_in_data (opcode, byte_in,
//   line_level); opcode is a command (bus reset, write byte, read byte)
//   taken only while no command runs, otherwise just a tick
// output channel: o_out_valid / i_out_ready with o_out_data, exactly one
//   result per request: drive_low for the open-drain pad, busy, done,
//   last read byte and presence flag
// config: i_cfg_we with i_cfg_idx and i_cfg_data writes one timing
//   register per clock; the user must write only while no request is
//   in flight, since the block itself does not enforce it
// path: a request is queued, then popped into the result register
// throughput: one request per clock while i_out_ready stays high
// the front decodes opcodes into a four-entry request queue; the back
//   engine pops a request when its result register is free or draining
// reset: synchronous active low; queue empties, engine goes idle,
//   timing registers return to their defaults, read byte and presence
//   clear
// stalls: when i_out_ready is low the result holds, the back stops,
//   the queue fills and o_in_ready drops once it is full
module one_wire_bus_master (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [owb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  owb_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output owb_pkg::t_out_item             o_out_data
);
    import owb_pkg::*;

    // front to queue
    t_cls_item front_item;
    t_cls_item q_item;
    t_q_ctrl   q_ctrl;
    t_q_stat   q_stat;
    logic      push;
    logic      pop;

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    owb_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_stat.full),
        .o_push     (push),
        .o_item     (front_item)
    );

    // short queue lets the front keep taking ticks while the result stalls
    owb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_item  (front_item),
        .o_stat  (q_stat),
        .o_item  (q_item)
    );

    // bus timing engine with timing registers and result register
    owb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_stat.valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
